@@ rtl/core/feq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// feq_pkg
// Shared widths, register codes, sequencer step codes and types of the
// four-band crossover equalizer.
// ----------------------------------------------------------------------------
package feq_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int POLE_W    = 16;
   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 12;
   localparam int CSR_W     = 16;
   localparam int IDX_W     = 3;

   localparam int NUM_FILT  = 3;
   localparam int NUM_BAND  = 4;

   // filter memories and bands: one guard bit for high, one more for presence
   localparam int MEM_W     = SAMPLE_W + 2;
   localparam int MPL_W     = (POLE_W > GAIN_W) ? POLE_W : GAIN_W;
   localparam int DIGITS    = (MPL_W + 1) / 2;
   localparam int MPL_PAD_W = 2 * DIGITS;
   localparam int CNT_W     = $clog2(DIGITS);
   localparam int ACC_W     = MEM_W + 1 + MPL_W + 2;
   localparam int OP_W      = 3;

   typedef enum logic [IDX_W-1:0] {
      REG_MAIN_POLE     = 3'd0,
      REG_BASS_POLE     = 3'd1,
      REG_TREBLE_POLE   = 3'd2,
      REG_BASS_GAIN     = 3'd3,
      REG_LOW_MID_GAIN  = 3'd4,
      REG_HIGH_MID_GAIN = 3'd5,
      REG_PRESENCE_GAIN = 3'd6
   } reg_idx_type;

   localparam logic [OP_W-1:0] OP_MAIN      = 3'd0;
   localparam logic [OP_W-1:0] OP_BASS      = 3'd1;
   localparam logic [OP_W-1:0] OP_TREBLE    = 3'd2;
   localparam logic [OP_W-1:0] OP_MIX_FIRST = 3'd3;
   localparam logic [OP_W-1:0] OP_MIX_LAST  = 3'd6;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1) << GAIN_FRAC;

   typedef struct packed {
      logic [NUM_FILT-1:0][POLE_W-1:0] pole;
      logic [NUM_BAND-1:0][GAIN_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic             load;
      logic             acc_load;
      logic [ACC_W-1:0] acc_init;
      logic [ACC_W-1:0] mcand;
      logic [MPL_W-1:0] mplier;
   } mac_cmd_type;

   typedef struct packed {
      logic             busy;
      logic [ACC_W-1:0] acc;
   } mac_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/feq_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// feq_ifs
// Valid/ready sample channels: input item and result item.
// ----------------------------------------------------------------------------
interface feq_req_if
   import feq_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface feq_rsp_if
   import feq_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

@@ rtl/core/feq_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// feq_csr
// Configuration registers: three crossover poles and four band gains.
// ----------------------------------------------------------------------------
module feq_csr
   import feq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wen,
   input  wire logic [IDX_W-1:0] csr_idx,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (reg_idx_type'(csr_idx))
            REG_MAIN_POLE:     cfg_in.pole[0] = csr_wdata[POLE_W-1:0];
            REG_BASS_POLE:     cfg_in.pole[1] = csr_wdata[POLE_W-1:0];
            REG_TREBLE_POLE:   cfg_in.pole[2] = csr_wdata[POLE_W-1:0];
            REG_BASS_GAIN:     cfg_in.gain[0] = csr_wdata[GAIN_W-1:0];
            REG_LOW_MID_GAIN:  cfg_in.gain[1] = csr_wdata[GAIN_W-1:0];
            REG_HIGH_MID_GAIN: cfg_in.gain[2] = csr_wdata[GAIN_W-1:0];
            REG_PRESENCE_GAIN: cfg_in.gain[3] = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FILT; i++) cfg_ff.pole[i] <= '0;
         for (int i = 0; i < NUM_BAND; i++) cfg_ff.gain[i] <= GAIN_UNITY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ rtl/core/feq_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// feq_mac
// Digit-serial multiply-accumulate: signed multiplicand times unsigned
// multiplier, two multiplier bits per cycle, LSB first.
// ----------------------------------------------------------------------------
module feq_mac
   import feq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  mac_cmd_type cmd,
   output mac_stat_type stat
);

   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]     a_ff, a_in;
   logic [ACC_W-1:0]     a3_ff, a3_in;
   logic [MPL_PAD_W-1:0] mpl_ff, mpl_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 prep_ff, prep_in;
   logic [ACC_W-1:0]     addend;

   always_comb begin
      case (mpl_ff[1:0])
         2'd0:    addend = '0;
         2'd1:    addend = a_ff;
         2'd2:    addend = a_ff << 1;
         default: addend = a3_ff;
      endcase
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      a3_in   = a3_ff;
      mpl_in  = mpl_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      prep_in = prep_ff;
      if (cmd.load) begin
         a_in    = cmd.mcand;
         mpl_in  = MPL_PAD_W'(cmd.mplier);
         cnt_in  = CNT_W'(DIGITS - 1);
         busy_in = 1'b1;
         prep_in = 1'b1;
         if (cmd.acc_load) begin
            acc_in = cmd.acc_init;
         end
      end else if (prep_ff) begin
         a3_in   = a_ff + (a_ff << 1);
         prep_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = acc_ff + addend;
         a_in   = a_ff << 2;
         a3_in  = a3_ff << 2;
         mpl_in = mpl_ff >> 2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         prep_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         prep_ff <= prep_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      a3_ff  <= a3_in;
      mpl_ff <= mpl_in;
   end

   assign stat.busy = busy_ff;
   assign stat.acc  = acc_ff;

endmodule
`default_nettype wire

@@ rtl/core/four_band_crossover_eq_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// four_band_crossover_eq_core
// Four-band equalizer built from three one-pole crossover filters.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Its seven multiplies (three filter poles,
// four band gains) run in turn through one multiply-accumulate unit that
// takes two multiplier bits per cycle. Each multiply has an issue step, a
// step that prepares the 3x multiple, the digit steps and a step that hands
// the product back. The result is written to the output register, and the
// core is ready for the next item in the same cycle that the result becomes
// valid. A finished result waits in the output register while the next item
// is accepted. Filter memories reset to zero, poles to 0 (pass-through),
// gains to unity (4096).
// ----------------------------------------------------------------------------
module four_band_crossover_eq_core
   import feq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   feq_req_if.sink               req_if,
   feq_rsp_if.source             rsp_if,
   input  wire logic             csr_wen,
   input  wire logic [IDX_W-1:0] csr_idx,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam int SUM_W = ACC_W - GAIN_FRAC;

   cfg_type      cfg;
   mac_cmd_type  cmd;
   mac_stat_type stat;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic signed [MEM_W-1:0] x_ff, x_in;
   logic signed [MEM_W-1:0] low_ff, low_in;
   logic signed [MEM_W-1:0] high_ff, high_in;
   logic signed [MEM_W-1:0] mem_ff [NUM_FILT];
   logic signed [MEM_W-1:0] mem_in [NUM_FILT];
   logic signed [MEM_W-1:0] band_ff [NUM_BAND];
   logic signed [MEM_W-1:0] band_in [NUM_BAND];

   logic                    is_filt;
   logic [OP_W-1:0]         mix_off;
   logic [1:0]              mix_idx;
   logic signed [MEM_W-1:0] xk;
   logic signed [MEM_W-1:0] mem_sel;
   logic [POLE_W-1:0]       pole_sel;
   logic signed [MEM_W:0]   diff;
   logic signed [ACC_W-1:0] xk_ext;
   logic signed [MEM_W-1:0] y;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-SAMPLE_W:0] sum_top;
   logic [SAMPLE_W-1:0]     sat;

   feq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   feq_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // operand selection for the current step
   always_comb begin
      is_filt = (op_ff < OP_MIX_FIRST);
      mix_off = op_ff - OP_MIX_FIRST;
      mix_idx = mix_off[1:0];
      case (op_ff)
         OP_MAIN: begin
            xk       = x_ff;
            mem_sel  = mem_ff[0];
            pole_sel = cfg.pole[0];
         end
         OP_BASS: begin
            xk       = low_ff;
            mem_sel  = mem_ff[1];
            pole_sel = cfg.pole[1];
         end
         default: begin
            xk       = high_ff;
            mem_sel  = mem_ff[2];
            pole_sel = cfg.pole[2];
         end
      endcase
      diff   = (MEM_W+1)'(mem_sel) - (MEM_W+1)'(xk);
      xk_ext = ACC_W'(xk);
   end

   // filter: y = x + p*(y_prev - x) / 2^P; mix: sum of band*gain / 2^F; rounded half up
   always_comb begin
      cmd.load = (state_ff == ST_ISSUE);
      if (is_filt) begin
         cmd.acc_load = 1'b1;
         cmd.acc_init = (xk_ext <<< POLE_W) | (ACC_W'(1) << (POLE_W - 1));
         cmd.mcand    = ACC_W'(diff);
         cmd.mplier   = MPL_W'(pole_sel);
      end else begin
         cmd.acc_load = (op_ff == OP_MIX_FIRST);
         cmd.acc_init = ACC_W'(1) << (GAIN_FRAC - 1);
         cmd.mcand    = ACC_W'(band_ff[mix_idx]);
         cmd.mplier   = MPL_W'(cfg.gain[mix_idx]);
      end
   end

   always_comb begin
      y       = $signed(stat.acc[POLE_W +: MEM_W]);
      sum     = $signed(stat.acc[ACC_W-1:GAIN_FRAC]);
      sum_top = sum[SUM_W-1:SAMPLE_W-1];
      if ((&sum_top) || (~|sum_top)) begin
         sat = sum[SAMPLE_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mem_in       = mem_ff;
      band_in      = band_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               x_in     = MEM_W'(req_if.sample_in);
               op_in    = OP_MAIN;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!stat.busy) begin
               case (op_ff)
                  OP_MAIN: begin
                     mem_in[0] = y;
                     low_in    = y;
                     high_in   = x_ff - y;
                  end
                  OP_BASS: begin
                     mem_in[1]  = y;
                     band_in[0] = y;
                     band_in[1] = low_ff - y;
                  end
                  OP_TREBLE: begin
                     mem_in[2]  = y;
                     band_in[2] = y;
                     band_in[3] = high_ff - y;
                  end
                  default: ;
               endcase
               if (op_ff == OP_MIX_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_data_in  = sat;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_MAIN;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_FILT; i++) mem_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         mem_ff       <= mem_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      band_ff     <= band_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff;

endmodule
`default_nettype wire

@@ dv/feq_eq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feq_eq_checker
// Watches the sample channels and the register port of the equalizer. It
// keeps its own copy of the registers and the three filter memories, works out
// each output sample when an input item is taken, and compares every returned
// item in order against the oldest prediction.
// ----------------------------------------------------------------------------
module feq_eq_checker
   import feq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       csr_wen,
   input  logic [IDX_W-1:0]           csr_idx,
   input  logic [CSR_W-1:0]           csr_wdata,
   output int unsigned                samples_pending,
   output int unsigned                mismatch_count
);

   localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

   logic [POLE_W-1:0]          pole_reg [NUM_FILT];
   logic [GAIN_W-1:0]          gain_reg [NUM_BAND];
   longint                     split_mem [NUM_FILT];
   logic signed [SAMPLE_W-1:0] expected_samples [$];
   int unsigned                errors = 0;

   // one-pole lowpass k, rounded half up, updates its memory
   function automatic longint lowpass(input longint x, input int k);
      longint p;
      longint acc;
      p   = longint'(pole_reg[k]);
      acc = ((longint'(1) <<< POLE_W) - p) * x + p * split_mem[k]
            + (longint'(1) <<< (POLE_W - 1));
      split_mem[k] = acc >>> POLE_W;
      return split_mem[k];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] equalize(
      input logic signed [SAMPLE_W-1:0] x_in);
      longint x, low, high, bass, low_mid, high_mid, presence, acc, s;
      x        = longint'(x_in);
      low      = lowpass(x, 0);
      high     = x - low;
      bass     = lowpass(low, 1);
      low_mid  = low - bass;
      high_mid = lowpass(high, 2);
      presence = high - high_mid;
      acc = bass * longint'(gain_reg[0]) + low_mid * longint'(gain_reg[1])
            + high_mid * longint'(gain_reg[2]) + presence * longint'(gain_reg[3])
            + (longint'(1) <<< (GAIN_FRAC - 1));
      s = acc >>> GAIN_FRAC;
      if (s > SAMPLE_MAX) s = SAMPLE_MAX;
      else if (s < SAMPLE_MIN) s = SAMPLE_MIN;
      return SAMPLE_W'(s);
   endfunction

   always @(posedge clock) begin : watch
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < NUM_FILT; i++) begin
            pole_reg[i]  = '0;
            split_mem[i] = 0;
         end
         for (int i = 0; i < NUM_BAND; i++) gain_reg[i] = GAIN_UNITY;
         expected_samples.delete();
      end else begin
         if (csr_wen) begin
            case (csr_idx)
               REG_MAIN_POLE:     pole_reg[0] = csr_wdata[POLE_W-1:0];
               REG_BASS_POLE:     pole_reg[1] = csr_wdata[POLE_W-1:0];
               REG_TREBLE_POLE:   pole_reg[2] = csr_wdata[POLE_W-1:0];
               REG_BASS_GAIN:     gain_reg[0] = csr_wdata[GAIN_W-1:0];
               REG_LOW_MID_GAIN:  gain_reg[1] = csr_wdata[GAIN_W-1:0];
               REG_HIGH_MID_GAIN: gain_reg[2] = csr_wdata[GAIN_W-1:0];
               REG_PRESENCE_GAIN: gain_reg[3] = csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_samples.push_back(equalize(req_sample));
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected sample_out %0d, nothing pending", $time, rsp_sample);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want) begin
                  $display("%0t: sample_out mismatch, expected %0d, got %0d",
                           $time, want, rsp_sample);
                  errors++;
               end
            end
         end
      end
      samples_pending <= expected_samples.size();
      mismatch_count  <= errors;
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the four-band crossover equalizer core. Directed
// samples cover pass-through, extreme poles and saturating gains; random
// phases then reprogram all registers and stream samples with random gaps
// and output stalls, while a checker predicts and compares each item.
// ----------------------------------------------------------------------------
module tb_top;
   import feq_pkg::*;

   localparam int CLK_PERIOD      = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int RANDOM_PHASES   = 10;
   localparam int SETTLE_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam logic [IDX_W-1:0]           REG_SPARE = 3'd7;
   localparam logic [CSR_W-1:0]           CSR_MAX   = '1;
   localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wen;
   logic [IDX_W-1:0]           csr_idx;
   logic [CSR_W-1:0]           csr_wdata;
   logic                       calm = 1'b0;
   logic signed [SAMPLE_W-1:0] last_sample = '0;
   int unsigned                samples_pending;
   int unsigned                mismatch_count;
   int unsigned                quiet_cycles = 0;

   feq_req_if req_ch ();
   feq_rsp_if rsp_ch ();

   four_band_crossover_eq_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_wen   (csr_wen),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   feq_eq_checker eq_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_sample      (req_ch.sample_in),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_sample      (rsp_ch.sample_out),
      .csr_wen         (csr_wen),
      .csr_idx         (csr_idx),
      .csr_wdata       (csr_wdata),
      .samples_pending (samples_pending),
      .mismatch_count  (mismatch_count)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mostly no gap, some short, a few long
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [CSR_W-1:0] pick_pole();
      case ($urandom_range(4))
         0: return '0;
         1: return CSR_MAX;
         2: return CSR_MAX - CSR_W'($urandom_range(1023));
         default: return CSR_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_gain();
      case ($urandom_range(5))
         0: return '0;
         1: return GAIN_UNITY;
         2: return CSR_MAX;
         3: return CSR_W'($urandom_range(8192));
         default: return CSR_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(99);
      if (r < 8) begin
         case ($urandom_range(3))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 20) return last_sample;
      if (r < 50) begin
         k = $urandom_range(SAMPLE_W - 1);
         return SAMPLE_W'($signed($urandom) >>> (31 - k));
      end
      return SAMPLE_W'($urandom);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= s;
      last_sample = s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic pause_sender(input int unsigned n);
      if (n == 0) return;
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // hold off input until every pending item has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_W-1:0] main_p, bass_p, treble_p,
                            input logic [CSR_W-1:0] bass_g, low_mid_g, high_mid_g,
                            input logic [CSR_W-1:0] presence_g);
      logic [CSR_W-1:0] plan [NUM_FILT + NUM_BAND];
      plan = '{main_p, bass_p, treble_p, bass_g, low_mid_g, high_mid_g, presence_g};
      for (int i = 0; i < NUM_FILT + NUM_BAND; i++) begin
         csr_wen   <= 1'b1;
         csr_idx   <= reg_idx_type'(i);
         csr_wdata <= plan[i];
         @(posedge clock);
      end
      // unmapped index, must have no effect
      csr_idx   <= REG_SPARE;
      csr_wdata <= CSR_W'($urandom);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin : stim
      int unsigned hold_at;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;
      csr_wen          = 1'b0;
      csr_idx          = '0;
      csr_wdata        = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pass-through at unity gain
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample('0);
      send_sample('1);
      send_sample(SAMPLE_W'(1));
      send_sample({(SAMPLE_W/2){2'b01}});
      send_sample({(SAMPLE_W/2){2'b10}});

      drain();
      configure(CSR_MAX, '0, 16'h8000, CSR_MAX, '0, GAIN_UNITY, CSR_MAX);
      send_sample(S_MAX);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(S_MIN);
      send_sample('0);

      // pass-through with maximum gains: saturation both ways
      drain();
      configure('0, '0, '0, CSR_MAX, CSR_MAX, CSR_MAX, CSR_MAX);
      send_sample(S_MAX);
      send_sample(S_MIN);
      send_sample(SAMPLE_W'(1));
      send_sample('1);

      drain();
      configure(CSR_MAX, CSR_MAX, CSR_MAX, GAIN_UNITY, 16'd2048, 16'd8192, '0);
      repeat (3) send_sample(S_MAX);
      repeat (3) send_sample(S_MIN);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         configure(pick_pole(), pick_pole(), pick_pole(),
                   pick_gain(), pick_gain(), pick_gain(), pick_gain());
         calm    = (ph % 4 == 1);
         hold_at = $urandom_range(1, ITEMS_PER_PHASE - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_sample(pick_sample());
            if (n == hold_at) drain();
            else pause_sender(gap_len());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin : rsp_side
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         hold = $urandom_range(1, 24);
         repeat (hold) @(posedge clock);
         hold = gap_len();
         if (hold != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/core/feq_pkg.sv
rtl/core/feq_ifs.sv
rtl/core/feq_csr.sv
rtl/core/feq_mac.sv
rtl/core/four_band_crossover_eq_core.sv
dv/feq_eq_checker.sv
dv/tb_top.sv
